/* rtl/core/gmhc_pkg.sv */
`default_nettype none
package gmhc_pkg;

  // Channel layout
  localparam int NUM_CHANNELS = 4;
  localparam int COLOUR_LANES = 3;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_MIN_GAIN = 2'd0;
  localparam logic [1:0] REG_MAX_GAIN = 2'd1;

  localparam logic [15:0] MIN_GAIN_RESET = 16'h0000;
  localparam logic [15:0] MAX_GAIN_RESET = 16'h1000;

  // Half-float codes
  localparam logic [15:0] HALF_QNAN = 16'h7E00;
  localparam logic [14:0] HALF_INF  = 15'h7C00;
  localparam logic [14:0] HALF_MAXF = 15'h7BFF;

  // Pipeline shape: decode with gain product, gain round, gain sum,
  // one stage per fraction bit of the exponent, then scale, align, pack
  localparam int EXP_STEPS  = 16;
  localparam int PIPE_DEPTH = EXP_STEPS + 6;

  // Saturated gain exponent magnitude in Q6.16 before clamp
  localparam logic [23:0] Q_SAT = 24'h800000;

  // Data that rides along a lane pipeline
  typedef struct packed {
    logic               sign;
    logic               spec;
    logic [15:0]        spec_val;
    logic [10:0]        sig;
    logic signed [6:0]  es;
    logic signed [6:0]  n;
  } lane_carry_t;

  // Root coefficients: c0 = 2^31, ck = floor(sqrt(c(k-1) * 2^30)), Q1.30
  function automatic logic [31:0] exp2_coef(input int k);
    logic [63:0] c;
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] bit_w;
    c = 64'd1 << 31;
    for (int i = 1; i <= k; i++) begin
      v     = c << 30;
      r     = 64'd0;
      bit_w = 64'd1 << 62;
      for (int j = 0; j < 32; j++) begin
        if (v >= r + bit_w) begin
          v = v - (r + bit_w);
          r = (r >> 1) + bit_w;
        end else begin
          r = r >> 1;
        end
        bit_w = bit_w >> 2;
      end
      c = r;
    end
    return c[31:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/core/gain_map_hdr_compositor.sv */
// Gain-map HDR compositor: one RGBA half-float SDR pixel plus its RGB
// half-float gain weights in, one RGBA half-float HDR pixel out.
// Input channel: in_valid/in_ready with sdr_* and gain_* fields.
// Output channel: out_valid/out_ready with hdr_* fields; hdr_alpha is the
// SDR alpha bits, delayed with the pixel.
// Configuration: cfg_write with cfg_index (0 min gain, 1 max gain, other
// indexes ignored) and cfg_data, both signed Q5.10; write only when idle.
// Throughput is one pixel per cycle while the receiver takes results: the
// pipeline has 22 register stages, 16 of them one per fraction bit of the
// gain exponent, each holding one 31x32 multiply.
// The whole pipeline advances together; when the receiver stalls with a
// result waiting, every stage holds and in_ready drops, so nothing is
// lost or repeated. Bubbles are not squeezed out; they move like pixels.
// Reset clears all valid bits and loads min gain 0.0, max gain 4.0.
`default_nettype none
module gain_map_hdr_compositor (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] sdr_red,
  input  wire logic [15:0] sdr_green,
  input  wire logic [15:0] sdr_blue,
  input  wire logic [15:0] sdr_alpha,
  input  wire logic [15:0] gain_red,
  input  wire logic [15:0] gain_green,
  input  wire logic [15:0] gain_blue,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [15:0] hdr_red,
  output logic      [15:0] hdr_green,
  output logic      [15:0] hdr_blue,
  output logic      [15:0] hdr_alpha
);
  import gmhc_pkg::*;

  // configuration registers
  logic [15:0] min_gain_log2;
  logic [15:0] max_gain_log2;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_gain_log2 <= MIN_GAIN_RESET;
      max_gain_log2 <= MAX_GAIN_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MIN_GAIN: min_gain_log2 <= cfg_data;
        REG_MAX_GAIN: max_gain_log2 <= cfg_data;
        default: ;
      endcase
    end
  end

  // valid bits travel with the data; the pipeline moves as one
  logic                  adv;
  logic [PIPE_DEPTH-1:0] vld;

  assign adv       = !vld[PIPE_DEPTH-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[PIPE_DEPTH-2:0], in_valid};
    end
  end

  // channel lanes
  logic [15:0] sdr_ch  [0:NUM_CHANNELS-1];
  logic [15:0] gain_ch [0:NUM_CHANNELS-1];
  logic [15:0] hdr_ch  [0:NUM_CHANNELS-1];

  assign sdr_ch[0] = sdr_red;
  assign sdr_ch[1] = sdr_green;
  assign sdr_ch[2] = sdr_blue;
  assign sdr_ch[3] = sdr_alpha;
  assign gain_ch[0] = gain_red;
  assign gain_ch[1] = gain_green;
  assign gain_ch[2] = gain_blue;
  assign gain_ch[3] = 16'h0000;   // alpha has no gain weight: +0

  for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_ch
    if (c < COLOUR_LANES) begin : g_lane
      gmhc_lane u_lane (
        .clk      (clk),
        .en       (adv),
        .sdr      (sdr_ch[c]),
        .gain     (gain_ch[c]),
        .min_gain (min_gain_log2),
        .max_gain (max_gain_log2),
        .hdr      (hdr_ch[c])
      );
    end else begin : g_pass
      // delay line matching the lane latency
      logic [15:0] dly [0:PIPE_DEPTH-1];
      always_ff @(posedge clk) begin
        if (adv) begin
          dly[0] <= sdr_ch[c];
          for (int i = 1; i < PIPE_DEPTH; i++) dly[i] <= dly[i-1];
        end
      end
      assign hdr_ch[c] = dly[PIPE_DEPTH-1];
    end
  end

  assign hdr_red   = hdr_ch[0];
  assign hdr_green = hdr_ch[1];
  assign hdr_blue  = hdr_ch[2];
  assign hdr_alpha = hdr_ch[3];

endmodule
`default_nettype wire

/* rtl/core/gmhc_lane.sv */
`default_nettype none
module gmhc_lane (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [15:0] sdr,
  input  wire logic [15:0] gain,
  input  wire logic [15:0] min_gain,
  input  wire logic [15:0] max_gain,
  output logic      [15:0] hdr
);
  import gmhc_pkg::*;

  // ---------------- stage 1: decode, span * weight ----------------
  logic               ss, gs;
  logic [4:0]         se, ge;
  logic [9:0]         sm, gm;
  logic signed [17:0] span;
  logic [17:0]        span_abs;
  logic [10:0]        gsig, sig;
  logic [4:0]         gexp, es;
  logic [27:0]        prod;
  logic [3:0]         lz;
  logic               found;
  logic               spec;
  logic [15:0]        spec_val;
  logic               ginf;

  always_comb begin
    ss = sdr[15]; se = sdr[14:10]; sm = sdr[9:0];
    gs = gain[15]; ge = gain[14:10]; gm = gain[9:0];
    span = $signed({{2{max_gain[15]}}, max_gain}) + 18'sd1024
         - $signed({{2{min_gain[15]}}, min_gain});
    span_abs = span[17] ? 18'(-span) : 18'(span);
    gsig = (ge != 5'd0) ? {1'b1, gm} : {1'b0, gm};
    gexp = (ge != 5'd0) ? ge : 5'd1;
    prod = 28'(span_abs[16:0]) * 28'(gsig);
    ginf = (ge == 5'd31) && (gm == 10'd0);
    // normalize the SDR significand
    sig = (se != 5'd0) ? {1'b1, sm} : {1'b0, sm};
    es  = (se != 5'd0) ? se : 5'd1;
    lz = 4'd0;
    found = 1'b0;
    for (int i = 10; i >= 0; i--) begin
      if (!found && sig[i]) begin
        lz = 4'(10 - i);
        found = 1'b1;
      end
    end
    // special operands, in priority order
    spec = 1'b1;
    if (se == 5'd31 && sm != 10'd0)      spec_val = HALF_QNAN;
    else if (ge == 5'd31 && gm != 10'd0) spec_val = HALF_QNAN;
    else if (ginf && span == 18'sd0)     spec_val = HALF_QNAN;
    else if (se == 5'd31)                spec_val = {ss, HALF_INF};
    else if (se == 5'd0 && sm == 10'd0)  spec_val = {ss, 15'd0};
    else begin
      spec = 1'b0;
      spec_val = 16'd0;
    end
  end

  logic [27:0]  r1_prod;
  logic [4:0]   r1_gexp;
  logic         r1_neg, r1_ginf;
  lane_carry_t  r1_c;

  always_ff @(posedge clk) begin
    if (en) begin
      r1_prod       <= prod;
      r1_gexp       <= gexp;
      r1_neg        <= span[17] ^ gs;
      r1_ginf       <= ginf;
      r1_c.sign     <= ss;
      r1_c.spec     <= spec;
      r1_c.spec_val <= spec_val;
      r1_c.sig      <= sig << lz;
      r1_c.es       <= $signed({2'b00, es}) - $signed({3'b000, lz});
      r1_c.n        <= 7'sd0;
    end
  end

  // ---------------- stage 2: align product to Q.16, round ----------------
  logic [3:0]  lsh;
  logic [39:0] wide;
  logic [4:0]  rsh;
  logic [27:0] qr, rmask, qi;
  logic        rb, sticky;
  logic [23:0] q;

  always_comb begin
    lsh   = 4'd0;
    wide  = 40'd0;
    rsh   = 5'd1;
    qr    = 28'd0;
    rmask = 28'd0;
    qi    = 28'd0;
    rb    = 1'b0;
    sticky = 1'b0;
    if (r1_ginf) begin
      q = Q_SAT;
    end else if (r1_gexp >= 5'd19) begin
      lsh  = 4'(r1_gexp - 5'd19);
      wide = 40'(r1_prod) << lsh;
      q = (|wide[39:23]) ? Q_SAT : {1'b0, wide[22:0]};
    end else begin
      rsh    = 5'd19 - r1_gexp;
      qr     = r1_prod >> rsh;
      rb     = r1_prod[rsh - 5'd1];
      rmask  = (28'd1 << (rsh - 5'd1)) - 28'd1;
      sticky = |(r1_prod & rmask);
      qi     = qr + 28'(rb & (sticky | qr[0]));
      q = (|qi[27:23]) ? Q_SAT : {1'b0, qi[22:0]};
    end
  end

  logic [23:0] r2_q;
  logic        r2_neg;
  lane_carry_t r2_c;

  always_ff @(posedge clk) begin
    if (en) begin
      r2_q   <= q;
      r2_neg <= r1_neg;
      r2_c   <= r1_c;
    end
  end

  // ---------------- stage 3: G = min + product, clamp ----------------
  logic signed [25:0] min64, qs, gsum;
  logic [22:0]        gval;
  lane_carry_t        c3;

  always_comb begin
    min64 = $signed({{4{min_gain[15]}}, min_gain, 6'b0});
    qs    = $signed({2'b00, r2_q});
    gsum  = r2_neg ? (min64 - qs) : (min64 + qs);
    if (gsum > 26'sd4194303)       gval = 23'h3FFFFF;
    else if (gsum < -26'sd4194304) gval = 23'h400000;
    else                           gval = gsum[22:0];
    // integer part of G rides along with the pixel
    c3   = r2_c;
    c3.n = $signed(gval[22:16]);
  end

  // exponent stages: index 0 is the stage 3 register
  logic [30:0]  e_pipe [0:EXP_STEPS];
  logic [15:0]  f_pipe [0:EXP_STEPS];
  lane_carry_t  c_pipe [0:EXP_STEPS];

  assign e_pipe[0] = 31'h40000000;

  always_ff @(posedge clk) begin
    if (en) begin
      f_pipe[0] <= gval[15:0];
      c_pipe[0] <= c3;
    end
  end

  // ---------------- stages 4..19: 2^f, one fraction bit each ----------------
  for (genvar k = 1; k <= EXP_STEPS; k++) begin : g_exp
    localparam logic [31:0] CK = exp2_coef(k);
    logic [62:0] mul;
    assign mul = 63'(e_pipe[k-1]) * 63'(CK);
    always_ff @(posedge clk) begin
      if (en) begin
        e_pipe[k] <= f_pipe[k-1][EXP_STEPS-k] ? mul[60:30] : e_pipe[k-1];
        f_pipe[k] <= f_pipe[k-1];
        c_pipe[k] <= c_pipe[k-1];
      end
    end
  end

  // ---------------- stage 20: scale significand ----------------
  lane_carry_t       ce;
  logic [41:0]       r20_p;
  logic signed [8:0] r20_s;
  lane_carry_t       r20_c;

  assign ce = c_pipe[EXP_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      r20_p <= 42'(ce.sig) * 42'(e_pipe[EXP_STEPS]);
      r20_s <= $signed({{2{ce.es[6]}}, ce.es}) - 9'sd55 + $signed({{2{ce.n[6]}}, ce.n});
      r20_c <= ce;
    end
  end

  // ---------------- stage 21: align to half grid ----------------
  logic signed [8:0] lsb, lsb_c;
  logic signed [9:0] shd;
  logic [5:0]        sh;
  logic [43:0]       pe, pmask;
  logic [43:0]       pshift;

  always_comb begin
    lsb   = r20_s + (r20_p[41] ? 9'sd31 : 9'sd30);
    lsb_c = (lsb < -9'sd24) ? -9'sd24 : lsb;
    shd   = 10'(lsb_c) - 10'(r20_s);
    sh    = (shd > 10'sd43) ? 6'd43 : shd[5:0];
    pe    = {2'b00, r20_p};
    pshift = pe >> sh;
    pmask = (44'd1 << (sh - 6'd1)) - 44'd1;
  end

  logic [11:0]       r21_m;
  logic              r21_rb, r21_st;
  logic signed [8:0] r21_lsb;
  lane_carry_t       r21_c;

  always_ff @(posedge clk) begin
    if (en) begin
      r21_m   <= pshift[11:0];
      r21_rb  <= pe[sh - 6'd1];
      r21_st  <= |(pe & pmask);
      r21_lsb <= lsb_c;
      r21_c   <= r20_c;
    end
  end

  // ---------------- stage 22: round to nearest even, pack ----------------
  logic [12:0]       m13;
  logic [10:0]       madj;
  logic signed [8:0] lsba;
  logic signed [8:0] ebias;
  logic [15:0]       packed_val;

  always_comb begin
    m13 = {1'b0, r21_m} + 13'(r21_rb & (r21_st | r21_m[0]));
    if (m13[11]) begin
      madj = m13[11:1];
      lsba = r21_lsb + 9'sd1;
    end else begin
      madj = m13[10:0];
      lsba = r21_lsb;
    end
    ebias = lsba + 9'sd25;
    if (!madj[10])           packed_val = {r21_c.sign, 5'd0, madj[9:0]};
    else if (lsba > 9'sd5)   packed_val = {r21_c.sign, HALF_MAXF};
    else                     packed_val = {r21_c.sign, ebias[4:0], madj[9:0]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hdr <= r21_c.spec ? r21_c.spec_val : packed_val;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/gmhc_checker.sv */
`default_nettype none
module gmhc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] hdr_red,
  input wire logic [15:0] hdr_green,
  input wire logic [15:0] hdr_blue,
  input wire logic [15:0] hdr_alpha
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output valid dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(hdr_red) && $stable(hdr_green)
      && $stable(hdr_blue) && $stable(hdr_alpha))
    else $error("output payload changed while stalled");

  // a stalled output takes no new transfer
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while output stalled");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind gain_map_hdr_compositor gmhc_checker u_gmhc_checker (.*);
`default_nettype wire

/* dv/tb_gain_map_hdr_compositor.sv */
`default_nettype none
module tb_gain_map_hdr_compositor;
  import gmhc_pkg::*;

  localparam int LATENCY   = PIPE_DEPTH;
  localparam int MAX_CYCLE = 400000;
  localparam int N_RANDOM  = 450;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] alpha;
  } hdr_pixel_t;

  typedef struct packed {
    logic [15:0] sr;
    logic [15:0] sg;
    logic [15:0] sb;
    logic [15:0] sa;
    logic [15:0] gr;
    logic [15:0] gg;
    logic [15:0] gb;
    logic        known;
    hdr_pixel_t  want;
  } pixel_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = REG_MIN_GAIN;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] sdr_red = '0, sdr_green = '0, sdr_blue = '0, sdr_alpha = '0;
  logic [15:0] gain_red = '0, gain_green = '0, gain_blue = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] hdr_red, hdr_green, hdr_blue, hdr_alpha;

  gain_map_hdr_compositor dut (.*);

  always #4 clk = ~clk;

  // Predictor state: gain registers and root coefficients
  logic signed [15:0] min_gain_q;
  logic signed [15:0] max_gain_q;
  logic [63:0]        root_coef [1:16];

  hdr_pixel_t pending_pixels[$];
  int  cycle_count = 0;
  int  error_count = 0;
  int  pixels_sent = 0;
  int  pixels_seen = 0;
  bit  rx_quiet = 1'b0;
  bit  busy_lull = 1'b0;

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r, bit_w;
    r = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w >>= 2;
    while (bit_w != 0) begin
      if (v >= r + bit_w) begin
        v = v - (r + bit_w);
        r = (r >> 1) + bit_w;
      end else begin
        r = r >> 1;
      end
      bit_w >>= 2;
    end
    return r;
  endfunction

  // sign * p * 2^s rounded to binary16
  function automatic logic [15:0] round_to_half(input logic sgn, input logic [63:0] p,
                                                input int s);
    int b, lsb, sh;
    logic [63:0] m, rem, hlf;
    b = 62;
    while (b > 0 && p[b] == 1'b0) b--;
    lsb = b + s - 10;
    if (lsb < -24) lsb = -24;
    sh = lsb - s;
    if (sh <= 0) begin
      m = p << (-sh);
    end else if (sh >= 64) begin
      m = 0;
    end else begin
      rem = p & ((64'd1 << sh) - 1);
      hlf = 64'd1 << (sh - 1);
      m = p >> sh;
      if (rem > hlf || (rem == hlf && m[0])) m++;
    end
    if (m >= 2048) begin
      m >>= 1;
      lsb++;
    end
    if (m < 1024) return {sgn, m[14:0]};
    if (lsb + 25 > 30) return {sgn, HALF_MAXF};
    return {sgn, 5'(lsb + 25), m[9:0]};
  endfunction

  // One colour lane: gain exponent in Q6.16, then sdr * 2^G
  function automatic logic [15:0] scale_lane(input logic [15:0] sdr, input logic [15:0] gain);
    longint span, g, gq, gu;
    logic [63:0] mag, gsig, prod, q, rem, hlf, e2, sig;
    int e, r, n, es;
    bit neg;
    span = longint'(max_gain_q) + 1024 - longint'(min_gain_q);
    neg = (span < 0) != gain[15];
    if (sdr[14:10] == 5'h1f && sdr[9:0] != 0) return HALF_QNAN;
    if (gain[14:10] == 5'h1f && gain[9:0] != 0) return HALF_QNAN;
    if (gain[14:10] == 5'h1f) begin
      if (span == 0) return HALF_QNAN;
      g = neg ? -4194304 : 4194303;
    end else begin
      mag = span < 0 ? -span : span;
      gsig = gain[14:10] != 0 ? {54'd1, gain[9:0]} : {54'd0, gain[9:0]};
      e = gain[14:10] != 0 ? int'(gain[14:10]) : 1;
      prod = mag * gsig;
      if (e >= 19) begin
        q = prod << (e - 19);
      end else begin
        r = 19 - e;
        rem = prod & ((64'd1 << r) - 1);
        hlf = 64'd1 << (r - 1);
        q = prod >> r;
        if (rem > hlf || (rem == hlf && q[0])) q++;
      end
      gq = longint'(q);
      g = longint'(min_gain_q) * 64 + (neg ? -gq : gq);
      if (g > 4194303) g = 4194303;
      if (g < -4194304) g = -4194304;
    end
    if (sdr[14:10] == 5'h1f) return {sdr[15], HALF_INF};
    if (sdr[14:0] == 0) return {sdr[15], 15'd0};
    gu = g + 4194304;
    n = int'(gu >>> 16) - 64;
    e2 = 64'd1 << 30;
    for (int k = 1; k <= 16; k++)
      if (gu[16 - k]) e2 = (e2 * root_coef[k]) >> 30;
    sig = sdr[14:10] != 0 ? {54'd1, sdr[9:0]} : {54'd0, sdr[9:0]};
    es = sdr[14:10] != 0 ? int'(sdr[14:10]) : 1;
    return round_to_half(sdr[15], sig * e2, es - 25 + n - 30);
  endfunction

  function automatic hdr_pixel_t predict_pixel(input pixel_row_t px);
    hdr_pixel_t h;
    h.red   = scale_lane(px.sr, px.gr);
    h.green = scale_lane(px.sg, px.gg);
    h.blue  = scale_lane(px.sb, px.gb);
    h.alpha = px.sa;
    return h;
  endfunction

  // Mostly gains in [0,1] and ordinary pixels, some fully random bits
  function automatic logic [15:0] rand_half(input bit wide);
    if (wide || $urandom_range(0, 9) == 0) return 16'($urandom);
    return {$urandom_range(0, 1) == 1, 5'($urandom_range(0, 30)), 10'($urandom)};
  endfunction

  function automatic logic [15:0] rand_weight();
    case ($urandom_range(0, 9))
      0: return 16'($urandom);
      1: return 16'h3C00;
      2: return {1'b0, 15'($urandom_range(0, 16'h3C00))};
      default: return {1'b0, 15'($urandom_range(0, 16'h3BFF))};
    endcase
  endfunction

  task automatic write_gain(input logic [1:0] idx, input logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_MIN_GAIN) min_gain_q = val;
    else if (idx == REG_MAX_GAIN) max_gain_q = val;
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // One transfer on the input channel; gaps only before raising valid
  task automatic send_pixel(input pixel_row_t px);
    pixel_row_t p;
    p = px;
    while (!busy_lull && $urandom_range(0, 99) < 18) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {sdr_red, sdr_green, sdr_blue, sdr_alpha} <= {px.sr, px.sg, px.sb, px.sa};
    {gain_red, gain_green, gain_blue} <= {px.gr, px.gg, px.gb};
    if (!p.known) p.want = predict_pixel(px);
    else if (p.want != predict_pixel(px)) begin
      $error("table row disagrees with predictor: %h vs %h", p.want, predict_pixel(px));
      error_count++;
    end
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_pixels.push_back(p.want);
    pixels_sent++;
  endtask

  function automatic pixel_row_t row(input logic [15:0] sr, sg, sb, sa, gr, gg, gb,
                                     input bit known, input hdr_pixel_t want);
    pixel_row_t r;
    r = '{sr, sg, sb, sa, gr, gg, gb, known, want};
    return r;
  endfunction

  // Output side: random stalls and in-order compare
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= rx_quiet || ($urandom_range(0, 99) >= 18);
      if (out_valid && out_ready) begin
        if (pending_pixels.size() == 0) begin
          $error("unexpected pixel transfer %h %h %h %h",
                 hdr_red, hdr_green, hdr_blue, hdr_alpha);
          error_count++;
        end else begin
          hdr_pixel_t w;
          w = pending_pixels.pop_front();
          pixels_seen++;
          if (hdr_red !== w.red) begin
            $error("hdr_red expected %h got %h", w.red, hdr_red); error_count++;
          end
          if (hdr_green !== w.green) begin
            $error("hdr_green expected %h got %h", w.green, hdr_green); error_count++;
          end
          if (hdr_blue !== w.blue) begin
            $error("hdr_blue expected %h got %h", w.blue, hdr_blue); error_count++;
          end
          if (hdr_alpha !== w.alpha) begin
            $error("hdr_alpha expected %h got %h", w.alpha, hdr_alpha); error_count++;
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLE) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  pixel_row_t  dir_rows [$];
  logic [15:0] gain_sets [6][2] = '{
    '{16'h0000, 16'h1000}, '{16'h8000, 16'h7FFF}, '{16'h7FFF, 16'h8000},
    '{16'hFC00, 16'h0400}, '{16'h0000, 16'hFC00}, '{16'h1C00, 16'hE000}};

  initial begin
    logic [63:0] c;
    c = 64'd1 << 31;
    for (int k = 1; k <= 16; k++) begin
      c = int_sqrt(c << 30);
      root_coef[k] = c;
    end
    min_gain_q = MIN_GAIN_RESET;
    max_gain_q = MAX_GAIN_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero gain keeps value, NaN, inf, zero, overflow, extremes
    dir_rows.push_back(row(16'h3C00, 16'h3C00, 16'h3C00, 16'h1234, 16'h0000, 16'h0000,
                           16'h0000, 1, '{16'h3C00, 16'h3C00, 16'h3C00, 16'h1234}));
    dir_rows.push_back(row(16'h7E01, 16'h3C00, 16'h3C00, 16'hFFFF, 16'h3C00, 16'h7C01,
                           16'h0000, 1, '{HALF_QNAN, HALF_QNAN, 16'h3C00, 16'hFFFF}));
    dir_rows.push_back(row(16'h7C00, 16'hFC00, 16'h0000, 16'h0000, 16'h3C00, 16'h3C00,
                           16'h3C00, 1, '{16'h7C00, 16'hFC00, 16'h0000, 16'h0000}));
    dir_rows.push_back(row(16'h8000, 16'h7BFF, 16'hFBFF, 16'h7C00, 16'h3C00, 16'h3C00,
                           16'h3C00, 1, '{16'h8000, 16'h7BFF, 16'hFBFF, 16'h7C00}));
    dir_rows.push_back(row(16'h3C00, 16'h0001, 16'h03FF, 16'hAAAA, 16'h7C00, 16'hFC00,
                           16'h3800, 0, '0));
    dir_rows.push_back(row(16'h0001, 16'h3555, 16'hC000, 16'h5555, 16'h0001, 16'h3BFF,
                           16'hBC00, 0, '0));
    dir_rows.push_back(row(16'h7BFF, 16'h0400, 16'h3C00, 16'h0001, 16'h7BFF, 16'hFBFF,
                           16'h3400, 0, '0));
    foreach (dir_rows[i]) send_pixel(dir_rows[i]);
    drain_and_settle();

    // Zero span with infinite gain gives NaN
    write_gain(REG_MIN_GAIN, 16'h0400);
    write_gain(REG_MAX_GAIN, 16'h0000);
    send_pixel(row(16'h3C00, 16'h3C00, 16'h3C00, 16'h0000, 16'h7C00, 16'hFC00, 16'h0000,
                   1, '{HALF_QNAN, HALF_QNAN, 16'h4000, 16'h0000}));
    drain_and_settle();
    write_gain(2'd3, 16'h7777);                      // ignored index
    send_pixel(row(16'h3C00, 16'h3C00, 16'h3C00, 16'h0000, 16'h3C00, 16'h0000, 16'h0000,
                   0, '0));
    drain_and_settle();

    // Random phases over several gain ranges
    for (int ph = 0; ph < 9; ph++) begin
      if (ph < 6) begin
        write_gain(REG_MIN_GAIN, gain_sets[ph][0]);
        write_gain(REG_MAX_GAIN, gain_sets[ph][1]);
      end else begin
        write_gain(REG_MIN_GAIN, 16'($urandom_range(0, 16'h1000) - 16'h0800));
        write_gain(REG_MAX_GAIN, 16'($urandom));
      end
      busy_lull = (ph == 3);
      rx_quiet  = (ph == 3);
      for (int i = 0; i < N_RANDOM / 9; i++) begin
        send_pixel(row(rand_half(0), rand_half(0), rand_half(0), 16'($urandom),
                       rand_weight(), rand_weight(), rand_weight(), 0, '0));
        // Sender holds off until the pipe is empty
        if (i == 20) begin
          in_valid <= 1'b0;
          while (pending_pixels.size() != 0) @(posedge clk);
        end
      end
      drain_and_settle();
    end

    $display("covered %0d pixels sent, %0d checked over 8+ gain settings",
             pixels_sent, pixels_seen);
    $display("directed specials: NaN, inf, zero, saturation, zero span, ignored index");
    if (error_count == 0 && pending_pixels.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
